/* rtl/pmpg_pkg.sv */
// Shared constants, sine table and rainbow palette for the plasma/moire pixel generator.
// No dependencies; imported by plasma_moire_pixel_generator.
package pmpg_pkg;

  // Frame geometry; sets the moire ring center.
  localparam int FRAME_WIDTH  = 320;
  localparam int FRAME_HEIGHT = 240;

  // Field widths.
  localparam int X_W     = 9;
  localparam int Y_W     = 8;
  localparam int TICK_W  = 8;
  localparam int VAL_W   = 8;
  localparam int COLOR_W = 24;
  localparam int CFG_W   = 8;

  // Center offsets in half-pixel units, signed; holds -1024..1023.
  localparam int OFS_W = 11;
  // Only the low bits of the squared distance reach the 8-bit value (>> 6).
  localparam int DIST_SHIFT = 6;
  localparam int SQ_W       = DIST_SHIFT + VAL_W;

  localparam logic [OFS_W-1:0] CENTER_X2 = OFS_W'(FRAME_WIDTH);
  localparam logic [OFS_W-1:0] CENTER_Y2 = OFS_W'(FRAME_HEIGHT);

  // Register indexes on the config port.
  localparam logic REG_EFFECT_MODE = 1'b0;
  localparam logic REG_FRAME_TICK  = 1'b1;

  // Effect select codes.
  localparam logic MODE_PLASMA = 1'b0;
  localparam logic MODE_MOIRE  = 1'b1;

  typedef enum logic [2:0] {
    SEG_BLACK_PURPLE = 3'd0,
    SEG_PURPLE_RED   = 3'd1,
    SEG_RED_ORANGE   = 3'd2,
    SEG_ORANGE_YEL   = 3'd3,
    SEG_YEL_GREEN    = 3'd4,
    SEG_GREEN_CYAN   = 3'd5,
    SEG_CYAN_BLUE    = 3'd6,
    SEG_BLUE_WHITE   = 3'd7
  } seg_e;

  // floor((sin(i*2pi/256) + 1) * 127.5)
  localparam logic [7:0] SINE_ROM [256] = '{
    8'd127, 8'd130, 8'd133, 8'd136, 8'd139, 8'd143, 8'd146, 8'd149,
    8'd152, 8'd155, 8'd158, 8'd161, 8'd164, 8'd167, 8'd170, 8'd173,
    8'd176, 8'd179, 8'd182, 8'd184, 8'd187, 8'd190, 8'd193, 8'd195,
    8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213, 8'd215,
    8'd217, 8'd219, 8'd221, 8'd224, 8'd226, 8'd228, 8'd229, 8'd231,
    8'd233, 8'd235, 8'd236, 8'd238, 8'd239, 8'd241, 8'd242, 8'd244,
    8'd245, 8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd251,
    8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
    8'd255, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd253, 8'd253,
    8'd252, 8'd251, 8'd251, 8'd250, 8'd249, 8'd248, 8'd247, 8'd246,
    8'd245, 8'd244, 8'd242, 8'd241, 8'd239, 8'd238, 8'd236, 8'd235,
    8'd233, 8'd231, 8'd229, 8'd228, 8'd226, 8'd224, 8'd221, 8'd219,
    8'd217, 8'd215, 8'd213, 8'd210, 8'd208, 8'd205, 8'd203, 8'd200,
    8'd198, 8'd195, 8'd193, 8'd190, 8'd187, 8'd184, 8'd182, 8'd179,
    8'd176, 8'd173, 8'd170, 8'd167, 8'd164, 8'd161, 8'd158, 8'd155,
    8'd152, 8'd149, 8'd146, 8'd143, 8'd139, 8'd136, 8'd133, 8'd130,
    8'd127, 8'd124, 8'd121, 8'd118, 8'd115, 8'd111, 8'd108, 8'd105,
    8'd102, 8'd99,  8'd96,  8'd93,  8'd90,  8'd87,  8'd84,  8'd81,
    8'd78,  8'd75,  8'd72,  8'd70,  8'd67,  8'd64,  8'd61,  8'd59,
    8'd56,  8'd54,  8'd51,  8'd49,  8'd46,  8'd44,  8'd41,  8'd39,
    8'd37,  8'd35,  8'd33,  8'd30,  8'd28,  8'd26,  8'd25,  8'd23,
    8'd21,  8'd19,  8'd18,  8'd16,  8'd15,  8'd13,  8'd12,  8'd10,
    8'd9,   8'd8,   8'd7,   8'd6,   8'd5,   8'd4,   8'd3,   8'd3,
    8'd2,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,
    8'd2,   8'd3,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,
    8'd9,   8'd10,  8'd12,  8'd13,  8'd15,  8'd16,  8'd18,  8'd19,
    8'd21,  8'd23,  8'd25,  8'd26,  8'd28,  8'd30,  8'd33,  8'd35,
    8'd37,  8'd39,  8'd41,  8'd44,  8'd46,  8'd49,  8'd51,  8'd54,
    8'd56,  8'd59,  8'd61,  8'd64,  8'd67,  8'd70,  8'd72,  8'd75,
    8'd78,  8'd81,  8'd84,  8'd87,  8'd90,  8'd93,  8'd96,  8'd99,
    8'd102, 8'd105, 8'd108, 8'd111, 8'd115, 8'd118, 8'd121, 8'd124
  };

  // Eight 32-entry ramps: black-purple-red-orange-yellow-green-cyan-blue-white.
  function automatic logic [COLOR_W-1:0] palette(input logic [VAL_W-1:0] v);
    logic [7:0] s4;
    logic [7:0] s8;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    s4 = {1'b0, v[4:0], 2'b00};
    s8 = {v[4:0], 3'b000};
    case (seg_e'(v[7:5]))
      SEG_BLACK_PURPLE: begin
        r = s4;            g = 8'd0;           b = 8'd128 - s4;
      end
      SEG_PURPLE_RED: begin
        r = 8'd128 + s4;   g = 8'd0;           b = 8'd0;
      end
      SEG_RED_ORANGE: begin
        r = 8'd255;        g = s4;             b = 8'd0;
      end
      SEG_ORANGE_YEL: begin
        r = 8'd255;        g = 8'd128 + s4;    b = 8'd0;
      end
      SEG_YEL_GREEN: begin
        r = 8'd255 - s4;   g = 8'd255;         b = s4;
      end
      SEG_GREEN_CYAN: begin
        r = 8'd128 - s4;   g = 8'd255;         b = 8'd255;
      end
      SEG_CYAN_BLUE: begin
        r = 8'd0;          g = 8'd255 - s4;    b = 8'd255;
      end
      default: begin
        r = s8;            g = s8;             b = 8'd255;
      end
    endcase
    return {r, g, b};
  endfunction

endpackage

/* rtl/plasma_moire_pixel_generator.sv */
// Top level of the plasma/moire pixel color generator: four-stage pipeline.
// Depends on pmpg_pkg (geometry, sine table, palette).
//
// Usage:
//   Pixel channel: in_valid_i/in_ready_o with pixel_x_i, pixel_y_i. One
//   transaction carries one coordinate; each produces exactly one color.
//   Color channel: out_valid_o/out_ready_i with color_o (R<<16|G<<8|B).
//   Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i at the
//   clock edge (index 0 = effect_mode, index 1 = frame_tick). Write only
//   while no pixel is in flight; new values apply to the next pixel.
// Throughput:
//   Each pixel passes through the stage registers in order and its color is
//   offered from the output register; one pixel per cycle sustained while
//   out_ready_i stays high. Stages: index/offset add, sine lookup and distance
//   squares (one 11x11 multiply each), value sum, palette lookup.
// Stalls:
//   Each stage has its own valid bit and loads when empty or when the next
//   stage moves, so bubbles collapse and input keeps flowing while a color
//   waits. With all four stages full and out_ready_i low, in_ready_o drops.
// Reset: rst_ni low empties the pipeline and sets plasma mode with tick 0.
module plasma_moire_pixel_generator
  import pmpg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // config
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  // pixel in
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [X_W-1:0]     pixel_x_i,
  input  logic [Y_W-1:0]     pixel_y_i,
  // color out
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [COLOR_W-1:0] color_o
);

  // ---------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------
  logic              mode_q;
  logic [TICK_W-1:0] tick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLASMA;
      tick_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_EFFECT_MODE: mode_q <= cfg_data_i[0];
        REG_FRAME_TICK:  tick_q <= cfg_data_i[TICK_W-1:0];
        default:         ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stage handshake: a stage loads when empty or when its content moves on
  // ---------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_ready_o  = rdy1;
  assign out_valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: sine indexes and center offsets
  // ---------------------------------------------------------------------
  logic [TICK_W-1:0]      tick3, tick5;
  logic [X_W:0]           sum_xy;
  logic [VAL_W-1:0]       idx_a_d, idx_b_d, idx_c_d;
  logic signed [OFS_W-1:0] ex_d, ey_d;

  assign tick3   = tick_q + {tick_q[TICK_W-2:0], 1'b0};
  assign tick5   = tick_q + {tick_q[TICK_W-3:0], 2'b00};
  assign sum_xy  = {1'b0, pixel_x_i} + {2'b00, pixel_y_i};
  assign idx_a_d = pixel_x_i[VAL_W-1:0] + tick_q;
  assign idx_b_d = pixel_y_i + tick3;
  assign idx_c_d = sum_xy[VAL_W:1] + tick5;
  // 2x - W and 2y - H, exact in OFS_W signed bits
  assign ex_d = $signed({1'b0, pixel_x_i, 1'b0} - CENTER_X2);
  assign ey_d = $signed({2'b00, pixel_y_i, 1'b0} - CENTER_Y2);

  logic [VAL_W-1:0]        idx_a_q, idx_b_q, idx_c_q;
  logic signed [OFS_W-1:0] ex_q, ey_q;
  logic                    mode1_q;
  logic [TICK_W-1:0]       tick1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      idx_a_q <= idx_a_d;
      idx_b_q <= idx_b_d;
      idx_c_q <= idx_c_d;
      ex_q    <= ex_d;
      ey_q    <= ey_d;
      mode1_q <= mode_q;
      tick1_q <= tick_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: sine lookups, squared offsets (low bits only)
  // ---------------------------------------------------------------------
  logic signed [2*OFS_W-1:0] sqx_full, sqy_full;

  assign sqx_full = ex_q * ex_q;
  assign sqy_full = ey_q * ey_q;

  logic [VAL_W-1:0]  sa_q, sb_q, sc_q;
  logic [SQ_W-1:0]   sqx_q, sqy_q;
  logic              mode2_q;
  logic [TICK_W-1:0] tick2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      sa_q    <= SINE_ROM[idx_a_q];
      sb_q    <= SINE_ROM[idx_b_q];
      sc_q    <= SINE_ROM[idx_c_q];
      sqx_q   <= sqx_full[SQ_W-1:0];
      sqy_q   <= sqy_full[SQ_W-1:0];
      mode2_q <= mode1_q;
      tick2_q <= tick1_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: 8-bit pattern value
  // ---------------------------------------------------------------------
  logic [SQ_W-1:0]   dist_sq;
  logic [TICK_W-1:0] tick8, tick11;
  logic [VAL_W-1:0]  moire_v, plasma_v, val_d;

  assign dist_sq  = sqx_q + sqy_q;
  assign tick8    = {tick2_q[TICK_W-4:0], 3'b000};
  assign tick11   = tick8 + {tick2_q[TICK_W-2:0], 1'b0} + tick2_q;
  assign moire_v  = (dist_sq[SQ_W-1:DIST_SHIFT] + tick8) ^ tick11;
  assign plasma_v = sa_q + sb_q + sc_q;
  assign val_d    = (mode2_q == MODE_MOIRE) ? moire_v : plasma_v;

  logic [VAL_W-1:0] val_q;

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      val_q <= val_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: palette, output register
  // ---------------------------------------------------------------------
  logic [COLOR_W-1:0] color_q;

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      color_q <= palette(val_q);
    end
  end

  assign color_o = color_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // An accepted pixel always lands in stage 1.
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v1_q)
    else $error("accepted pixel not captured in stage 1");

  // A stalled stage-3 value is neither lost nor changed.
  a_s3_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !rdy4) |=> (v3_q && $stable(val_q)))
    else $error("stalled stage 3 value lost or changed");

  // Input can only be refused when every stage is occupied.
  a_refuse_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && v4_q && !out_ready_i))
    else $error("input refused with room in pipeline");

  // With the receiver always ready, an accepted pixel moves unstalled through every stage onto the output.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && out_ready_i) ##1 out_ready_i ##1 out_ready_i
      ##1 out_ready_i |=> out_valid_o)
    else $error("color missing four cycles after accept");

endmodule

/* tb/plasma_moire_pixel_generator_tb.sv */
// Self-checking testbench for plasma_moire_pixel_generator: directed table, then random phases.
// Depends on pmpg_pkg (port widths, register indexes, mode codes, palette segment enum).
`timescale 1ns / 1ps

module plasma_moire_pixel_generator_tb
  import pmpg_pkg::*;
();

  // Frame geometry the moire center is measured from.
  localparam int SCREEN_W = 320;
  localparam int SCREEN_H = 240;

  // Random part: one register setting per phase, fixed transaction count per phase.
  localparam int NUM_PHASES  = 10;
  localparam int PHASE_ITEMS = 88;

  // Generous hard stop, far beyond the slowest legal run (ns).
  localparam int TIMEOUT_NS = 400_000;

  // Truncated sine: floor((sin(i*2pi/256) + 1) * 127.5).
  localparam logic [7:0] WAVE_TABLE [256] = '{
    127,130,133,136,139,143,146,149,152,155,158,161,164,167,170,173,
    176,179,182,184,187,190,193,195,198,200,203,205,208,210,213,215,
    217,219,221,224,226,228,229,231,233,235,236,238,239,241,242,244,
    245,246,247,248,249,250,251,251,252,253,253,254,254,254,254,254,
    255,254,254,254,254,254,253,253,252,251,251,250,249,248,247,246,
    245,244,242,241,239,238,236,235,233,231,229,228,226,224,221,219,
    217,215,213,210,208,205,203,200,198,195,193,190,187,184,182,179,
    176,173,170,167,164,161,158,155,152,149,146,143,139,136,133,130,
    127,124,121,118,115,111,108,105,102, 99, 96, 93, 90, 87, 84, 81,
     78, 75, 72, 70, 67, 64, 61, 59, 56, 54, 51, 49, 46, 44, 41, 39,
     37, 35, 33, 30, 28, 26, 25, 23, 21, 19, 18, 16, 15, 13, 12, 10,
      9,  8,  7,  6,  5,  4,  3,  3,  2,  1,  1,  0,  0,  0,  0,  0,
      0,  0,  0,  0,  0,  0,  1,  1,  2,  3,  3,  4,  5,  6,  7,  8,
      9, 10, 12, 13, 15, 16, 18, 19, 21, 23, 25, 26, 28, 30, 33, 35,
     37, 39, 41, 44, 46, 49, 51, 54, 56, 59, 61, 64, 67, 70, 72, 75,
     78, 81, 84, 87, 90, 93, 96, 99,102,105,108,111,115,118,121,124
  };

  // Directed table: a row is either a register write or one pixel transaction.
  typedef enum bit {
    ROW_PIXEL,
    ROW_WRITE
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic               idx;
    logic [CFG_W-1:0]   data;
    logic [X_W-1:0]     x;
    logic [Y_W-1:0]     y;
    bit                 typed;   // color below is the expectation, else predicted
    logic [COLOR_W-1:0] color;
  } dir_row_t;

  localparam int NUM_ROWS = 27;

  localparam dir_row_t PLAN [NUM_ROWS] = '{
    // straight out of reset: plasma, tick 0; all three lookups hit entry 0
    '{ROW_PIXEL, REG_EFFECT_MODE, 8'h00, 9'd0,   8'd0,   1'b1, 24'hFFF400},
    '{ROW_PIXEL, REG_EFFECT_MODE, 8'h00, 9'd319, 8'd239, 1'b0, 24'h0},
    // outside the frame: all coordinate bits set, then just past the edge
    '{ROW_PIXEL, REG_EFFECT_MODE, 8'h00, 9'd511, 8'd255, 1'b0, 24'h0},
    '{ROW_PIXEL, REG_EFFECT_MODE, 8'h00, 9'd320, 8'd240, 1'b0, 24'h0},
    // x wraps through the 8-bit table index
    '{ROW_PIXEL, REG_EFFECT_MODE, 8'h00, 9'd256, 8'd0,   1'b0, 24'h0},
    '{ROW_PIXEL, REG_EFFECT_MODE, 8'h00, 9'd255, 8'd255, 1'b0, 24'h0},
    '{ROW_WRITE, REG_FRAME_TICK,  8'hFF, 9'd0,   8'd0,   1'b0, 24'h0},
    '{ROW_PIXEL, REG_EFFECT_MODE, 8'h00, 9'd0,   8'd0,   1'b0, 24'h0},
    '{ROW_PIXEL, REG_EFFECT_MODE, 8'h00, 9'd511, 8'd255, 1'b0, 24'h0},
    '{ROW_PIXEL, REG_EFFECT_MODE, 8'h00, 9'd319, 8'd239, 1'b0, 24'h0},
    '{ROW_WRITE, REG_EFFECT_MODE, 8'h01, 9'd0,   8'd0,   1'b0, 24'h0},
    '{ROW_WRITE, REG_FRAME_TICK,  8'h00, 9'd0,   8'd0,   1'b0, 24'h0},
    // moire, tick 0: dead center gives level 0, top-left corner level 196
    '{ROW_PIXEL, REG_EFFECT_MODE, 8'h00, 9'd160, 8'd120, 1'b1, 24'h000080},
    '{ROW_PIXEL, REG_EFFECT_MODE, 8'h00, 9'd0,   8'd0,   1'b1, 24'h00EFFF},
    '{ROW_PIXEL, REG_EFFECT_MODE, 8'h00, 9'd511, 8'd255, 1'b0, 24'h0},
    '{ROW_PIXEL, REG_EFFECT_MODE, 8'h00, 9'd319, 8'd239, 1'b0, 24'h0},
    '{ROW_PIXEL, REG_EFFECT_MODE, 8'h00, 9'd320, 8'd240, 1'b0, 24'h0},
    '{ROW_WRITE, REG_FRAME_TICK,  8'hFF, 9'd0,   8'd0,   1'b0, 24'h0},
    '{ROW_PIXEL, REG_EFFECT_MODE, 8'h00, 9'd0,   8'd0,   1'b0, 24'h0},
    '{ROW_PIXEL, REG_EFFECT_MODE, 8'h00, 9'd160, 8'd120, 1'b0, 24'h0},
    '{ROW_PIXEL, REG_EFFECT_MODE, 8'h00, 9'd511, 8'd0,   1'b0, 24'h0},
    // mode write with upper bits set: only bit 0 counts, so back to plasma
    '{ROW_WRITE, REG_EFFECT_MODE, 8'hFE, 9'd0,   8'd0,   1'b0, 24'h0},
    '{ROW_PIXEL, REG_EFFECT_MODE, 8'h00, 9'd100, 8'd100, 1'b0, 24'h0},
    '{ROW_WRITE, REG_EFFECT_MODE, 8'hFF, 9'd0,   8'd0,   1'b0, 24'h0},
    '{ROW_WRITE, REG_FRAME_TICK,  8'h80, 9'd0,   8'd0,   1'b0, 24'h0},
    '{ROW_PIXEL, REG_EFFECT_MODE, 8'h00, 9'd161, 8'd121, 1'b0, 24'h0},
    '{ROW_PIXEL, REG_EFFECT_MODE, 8'h00, 9'd159, 8'd119, 1'b0, 24'h0}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [CFG_W-1:0]   cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [X_W-1:0]     pixel_x_i;
  logic [Y_W-1:0]     pixel_y_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [COLOR_W-1:0] color_o;

  // Shadow copy of the two registers, as the predictor sees them.
  logic               shadow_mode;
  logic [7:0]         shadow_tick;

  // Colors still owed by the block, oldest first.
  logic [COLOR_W-1:0] expected_colors [$];
  logic [COLOR_W-1:0] oldest_color;

  int                 mismatch_count;
  bit                 idling_on;      // random gaps on both channels
  int                 stall_left;     // receiver stall burst countdown

  plasma_moire_pixel_generator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pixel_x_i   (pixel_x_i),
    .pixel_y_i   (pixel_y_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .color_o     (color_o)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Color predictor
  // ---------------------------------------------------------------------------

  // Eight 32-step ramps, black through purple, red, yellow, green, cyan, blue to white.
  function automatic logic [COLOR_W-1:0] rainbow_rgb(input logic [7:0] level);
    int s;
    int r;
    int g;
    int b;
    s = int'(level[4:0]);
    case (seg_e'(level[7:5]))
      SEG_BLACK_PURPLE: begin r = s * 4;       g = 0;           b = 128 - s * 4; end
      SEG_PURPLE_RED:   begin r = 128 + s * 4; g = 0;           b = 0;           end
      SEG_RED_ORANGE:   begin r = 255;         g = s * 4;       b = 0;           end
      SEG_ORANGE_YEL:   begin r = 255;         g = 128 + s * 4; b = 0;           end
      SEG_YEL_GREEN:    begin r = 255 - s * 4; g = 255;         b = s * 4;       end
      SEG_GREEN_CYAN:   begin r = 128 - s * 4; g = 255;         b = 255;         end
      SEG_CYAN_BLUE:    begin r = 0;           g = 255 - s * 4; b = 255;         end
      default:          begin r = s * 8;       g = s * 8;       b = 255;         end
    endcase
    return {8'(r), 8'(g), 8'(b)};
  endfunction

  // Three sine lookups that drift at tick rates 1, 3 and 5, summed modulo 256.
  function automatic logic [7:0] plasma_level(input int x, input int y, input int t);
    logic [7:0] ia;
    logic [7:0] ib;
    logic [7:0] ic;
    ia = 8'(x + t);
    ib = 8'(y + 3 * t);
    ic = 8'(((x + y) >> 1) + 5 * t);
    return 8'(WAVE_TABLE[ia] + WAVE_TABLE[ib] + WAVE_TABLE[ic]);
  endfunction

  // Squared distance in half-pixel units, >> 6, shifted by 8t and XORed with 11t.
  function automatic logic [7:0] moire_level(input int x, input int y, input int t);
    int         ex;
    int         ey;
    logic [7:0] ring;
    ex   = 2 * x - SCREEN_W;
    ey   = 2 * y - SCREEN_H;
    ring = 8'((ex * ex + ey * ey) >> 6);
    return 8'(ring + 8 * t) ^ 8'(11 * t);
  endfunction

  function automatic logic [COLOR_W-1:0] pixel_color(input logic [X_W-1:0] x,
                                                     input logic [Y_W-1:0] y);
    if (shadow_mode == MODE_MOIRE) begin
      return rainbow_rgb(moire_level(int'(x), int'(y), int'(shadow_tick)));
    end
    return rainbow_rgb(plasma_level(int'(x), int'(y), int'(shadow_tick)));
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Every color transaction is matched against the oldest open expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_colors.size() == 0) begin
        flag_mismatch($sformatf("color %06h arrived with nothing expected", color_o));
      end else begin
        oldest_color = expected_colors.pop_front();
        if (color_o !== oldest_color) begin
          flag_mismatch($sformatf("color got %06h want %06h", color_o, oldest_color));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: out_ready_i drops in stall bursts while idling is on.
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i = 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      stall_left  = $urandom_range(1, 6) - 1;
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Called at a falling edge; returns at the falling edge after the transaction,
  // with in_valid_i still high so back-to-back pixels leave no gap.
  task automatic send_pixel(input logic [X_W-1:0] x, input logic [Y_W-1:0] y,
                            input bit typed, input logic [COLOR_W-1:0] typed_color);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    pixel_x_i  = x;
    pixel_y_i  = y;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_colors.push_back(typed ? typed_color : pixel_color(x, y));
    @(negedge clk_i);
  endtask

  // Stop sending and hold until every owed color has come back.
  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (expected_colors.size() != 0) @(negedge clk_i);
  endtask

  // One-cycle register write; the pipeline must be empty.
  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == REG_EFFECT_MODE) begin
      shadow_mode = data[0];
    end else begin
      shadow_tick = data;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    logic [X_W-1:0]   rx;
    logic [Y_W-1:0]   ry;
    logic [CFG_W-1:0] mode_data;
    logic [CFG_W-1:0] tick_data;

    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = REG_EFFECT_MODE;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    pixel_x_i      = '0;
    pixel_y_i      = '0;
    shadow_mode    = MODE_PLASMA;
    shadow_tick    = '0;
    mismatch_count = 0;
    idling_on      = 1'b1;

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table: writes wait for the pipeline to empty first.
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (PLAN[i].kind == ROW_WRITE) begin
        wait_drained();
        write_reg(PLAN[i].idx, PLAN[i].data);
      end else begin
        send_pixel(PLAN[i].x, PLAN[i].y, PLAN[i].typed, PLAN[i].color);
      end
    end

    // Random phases. The first four pin both registers at their extremes; the
    // rest pick random settings, mode data with random upper bits. Each phase
    // boundary drains the pipeline, so the sender pauses for all results there.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      // some phases run with no gaps; the closing one always does
      idling_on = (ph != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      case (ph)
        0:       begin mode_data = 8'h00; tick_data = 8'h00; end
        1:       begin mode_data = 8'h01; tick_data = 8'hFF; end
        2:       begin mode_data = 8'h00; tick_data = 8'hFF; end
        3:       begin mode_data = 8'h01; tick_data = 8'h00; end
        default: begin
          mode_data = 8'($urandom);
          tick_data = 8'($urandom);
        end
      endcase
      write_reg(REG_EFFECT_MODE, mode_data);
      write_reg(REG_FRAME_TICK, tick_data);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // mostly on-screen pixels, one in eight anywhere the port widths allow
        if ($urandom_range(0, 7) == 0) begin
          rx = 9'($urandom_range(0, 511));
          ry = 8'($urandom_range(0, 255));
        end else begin
          rx = 9'($urandom_range(0, SCREEN_W - 1));
          ry = 8'($urandom_range(0, SCREEN_H - 1));
        end
        send_pixel(rx, ry, 1'b0, '0);
      end
    end

    wait_drained();
    // idle for longer than the pipeline depth to catch stray colors
    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

endmodule
